@@ hw/rtl/rgbhsv_pkg.sv @@
package rgbhsv_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned FracW = 16;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } pix_in_t;

  typedef struct packed {
    logic [FracW-1:0] hue;
    logic [FracW-1:0] saturation;
    logic [ChanW-1:0] brightness;
    logic [ChanW-1:0] alpha_out;
  } hsv_out_t;

endpackage

@@ hw/rtl/rgb_to_hsv_converter_top.sv @@
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o   in_data_i   (red, green, blue, alpha)
// out       output     out_valid_o/out_ready_i out_data_o  (hue, saturation, brightness,
//                                                            alpha_out)
//
// One item per clock is accepted while the output side keeps up.
// Each item passes one front-end stage, which finds max, min and the hue
// numerator, and then four divider stages that each resolve four quotient
// bits of both hue and saturation.
// Reset clears only the stage valid bits; data registers are not reset.
// A stall at the output holds every full stage; empty stages keep filling,
// so up to five items sit in the pipeline before in_ready_o drops.
module rgb_to_hsv_converter_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rgbhsv_pkg::pix_in_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rgbhsv_pkg::hsv_out_t out_data_o
);

  localparam int unsigned BitsPerStg = 4;
  localparam int unsigned NumDiv     = rgbhsv_pkg::FracW / BitsPerStg;
  localparam int unsigned NumStg     = NumDiv + 1;

  // The hue divisor is 6*delta, at most 1530, so 11 bits hold it and the
  // remainder. The saturation dividend 65535*delta needs 24 bits.
  typedef struct packed {
    logic [10:0] hrem;
    logic [10:0] hden;
    logic [15:0] hq;
    logic [7:0]  srem;
    logic [15:0] sbits;
    logic [15:0] sq;
    logic [7:0]  hi;
    logic [7:0]  alpha;
    logic        gray;
  } stage_t;

  logic [NumStg-1:0] valid_q;
  logic [NumStg-1:0] adv;
  stage_t            stg_q [NumStg];
  stage_t            stg_d [NumStg];
  stage_t            front;

  logic [7:0]  r, g, b, hi, lo, delta;
  logic [10:0] d6, num;
  logic [23:0] sat_n;

  // Restoring division, several bits per call. Hue is a fractional quotient
  // of num/(6*delta); saturation is an integer quotient of 65535*delta/max.
  function automatic stage_t div_step(stage_t s);
    stage_t     t;
    logic [11:0] h2;
    logic [8:0]  s2;
    t = s;
    for (int k = 0; k < BitsPerStg; k++) begin
      h2 = {t.hrem, 1'b0};
      if (h2 >= {1'b0, t.hden}) begin
        t.hrem = 11'(h2 - {1'b0, t.hden});
        t.hq   = {t.hq[14:0], 1'b1};
      end else begin
        t.hrem = h2[10:0];
        t.hq   = {t.hq[14:0], 1'b0};
      end
      s2      = {t.srem, t.sbits[15]};
      t.sbits = {t.sbits[14:0], 1'b0};
      if (s2 >= {1'b0, t.hi}) begin
        t.srem = 8'(s2 - {1'b0, t.hi});
        t.sq   = {t.sq[14:0], 1'b1};
      end else begin
        t.srem = s2[7:0];
        t.sq   = {t.sq[14:0], 1'b0};
      end
    end
    return t;
  endfunction

  // Front end: largest and smallest channel, sector offset and hue numerator.
  always_comb begin
    r = in_data_i.red;
    g = in_data_i.green;
    b = in_data_i.blue;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    if (r >= g && r >= b) begin
      hi = r;
    end else if (g >= b) begin
      hi = g;
    end else begin
      hi = b;
    end
    delta = hi - lo;
    d6    = ({3'b000, delta} << 2) + ({3'b000, delta} << 1);
    sat_n = {delta, 16'h0000} - {16'h0000, delta};
    // Red wins ties, then green; for a nonzero delta the numerator lands in [0, 6*delta).
    if (r >= g && r >= b) begin
      if (g >= b) begin
        num = {3'b000, 8'(g - b)};
      end else begin
        num = d6 - {3'b000, 8'(b - g)};
      end
    end else if (g >= b) begin
      num = {2'b00, delta, 1'b0} + {3'b000, b} - {3'b000, r};
    end else begin
      num = {1'b0, delta, 2'b00} + {3'b000, r} - {3'b000, g};
    end

    front       = '0;
    front.hrem  = num;
    front.hden  = d6;
    front.srem  = sat_n[23:16];
    front.sbits = sat_n[15:0];
    front.hi    = hi;
    front.alpha = in_data_i.alpha;
    front.gray  = (delta == 8'h00);
  end

  always_comb begin
    stg_d[0] = front;
    for (int i = 1; i < NumStg; i++) begin
      stg_d[i] = div_step(stg_q[i-1]);
    end
  end

  // A stage takes new contents when it is empty or its successor moves on.
  always_comb begin
    adv[NumStg-1] = !valid_q[NumStg-1] || out_ready_i;
    for (int i = NumStg - 2; i >= 0; i--) begin
      adv[i] = !valid_q[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NumStg; i++) begin
        if (adv[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumStg; i++) begin
      if (adv[i]) begin
        stg_q[i] <= stg_d[i];
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[NumStg-1];

  always_comb begin
    out_data_o.hue        = stg_q[NumStg-1].gray ? '0 : stg_q[NumStg-1].hq;
    out_data_o.saturation = stg_q[NumStg-1].gray ? '0 : stg_q[NumStg-1].sq;
    out_data_o.brightness = stg_q[NumStg-1].hi;
    out_data_o.alpha_out  = stg_q[NumStg-1].alpha;
  end

  // An accepted item always lands in the front-end stage.
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0])
    else $error("accepted item did not enter the front-end stage");

  // Backpressure reaches the input only when the output is stalled.
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while the output was free");

  // Both divisions start with a remainder below the divisor.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] && !stg_q[0].gray |->
      (stg_q[0].hrem < stg_q[0].hden) && (stg_q[0].srem < stg_q[0].hi))
    else $error("divider started with a remainder out of range");

  // The front-end stage, when full and stalled by its successor, keeps its item.
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] && !adv[0] |=> valid_q[0] && $stable(stg_q[0]))
    else $error("stalled front-end stage lost its item");

endmodule

@@ verif/rgb_to_hsv_converter_top_test.sv @@
module rgb_to_hsv_converter_top_test;

  class pixel_scoreboard;
    rgbhsv_pkg::hsv_out_t expected_hsv[$];
    int unsigned          pixels_in;
    int unsigned          results_checked;
    int unsigned          mismatches;

    // Integer form of the HSV conversion; all quotients are floors.
    function rgbhsv_pkg::hsv_out_t predict_hsv(rgbhsv_pkg::pix_in_t pix);
      rgbhsv_pkg::hsv_out_t res;
      int                   r, g, b, hi, lo, delta, num;
      r = pix.red;
      g = pix.green;
      b = pix.blue;
      hi = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      lo = r;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      delta = hi - lo;
      res.hue = '0;
      res.saturation = '0;
      res.brightness = rgbhsv_pkg::ChanW'(hi);
      res.alpha_out = pix.alpha;
      if (delta != 0) begin
        res.saturation = rgbhsv_pkg::FracW'((65535 * delta) / hi);
        // Ties go to red first, then green.
        if (r == hi) begin
          if (g >= b) num = g - b;
          else num = 6 * delta - (b - g);
        end else if (g == hi) begin
          num = 2 * delta + b - r;
        end else begin
          num = 4 * delta + r - g;
        end
        res.hue = rgbhsv_pkg::FracW'((num * 65536) / (6 * delta));
      end
      return res;
    endfunction

    function void note_pixel(rgbhsv_pkg::pix_in_t pix);
      pixels_in++;
      expected_hsv.push_back(predict_hsv(pix));
    endfunction

    function void check_hsv(rgbhsv_pkg::hsv_out_t got);
      rgbhsv_pkg::hsv_out_t want;
      results_checked++;
      if (expected_hsv.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with no pending pixel: hue=%h sat=%h val=%h a=%h",
                   got.hue, got.saturation, got.brightness, got.alpha_out);
        return;
      end
      want = expected_hsv.pop_front();
      if (got.hue !== want.hue || got.saturation !== want.saturation ||
          got.brightness !== want.brightness || got.alpha_out !== want.alpha_out) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d exp hue=%h sat=%h val=%h a=%h",
                   results_checked, want.hue, want.saturation, want.brightness,
                   want.alpha_out);
          $display("       got hue=%h sat=%h val=%h a=%h",
                   got.hue, got.saturation, got.brightness, got.alpha_out);
        end
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  rgbhsv_pkg::pix_in_t  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  rgbhsv_pkg::hsv_out_t out_data_o;

  logic        quiet = 1'b0;
  int unsigned stall_left = 0;

  pixel_scoreboard sb = new;

  rgb_to_hsv_converter_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned idle_length();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic int unsigned pick_gap();
    if (quiet || $urandom_range(0, 99) < 55) return 0;
    return idle_length();
  endfunction

  function automatic logic [rgbhsv_pkg::ChanW-1:0] corner_value();
    if ($urandom_range(0, 1)) return rgbhsv_pkg::ChanW'(254 + $urandom_range(0, 1));
    return rgbhsv_pkg::ChanW'($urandom_range(0, 1));
  endfunction

  function automatic rgbhsv_pkg::pix_in_t make_pixel(int r, int g, int b, int a);
    rgbhsv_pkg::pix_in_t p;
    p.red = rgbhsv_pkg::ChanW'(r);
    p.green = rgbhsv_pkg::ChanW'(g);
    p.blue = rgbhsv_pkg::ChanW'(b);
    p.alpha = rgbhsv_pkg::ChanW'(a);
    return p;
  endfunction

  function automatic rgbhsv_pkg::pix_in_t random_pixel();
    rgbhsv_pkg::pix_in_t p;
    int unsigned         top, base;
    p = make_pixel($urandom, $urandom, $urandom, $urandom);
    case ($urandom_range(0, 9))
      4: begin
        p.green = p.red;
        p.blue = p.red;
      end
      5: begin
        top = $urandom_range(1, 255);
        case ($urandom_range(0, 2))
          0: p = make_pixel(top, top, $urandom_range(0, top), p.alpha);
          1: p = make_pixel($urandom_range(0, top), top, top, p.alpha);
          default: p = make_pixel(top, $urandom_range(0, top), top, p.alpha);
        endcase
      end
      6: begin
        p.red = corner_value();
        p.green = corner_value();
        p.blue = corner_value();
      end
      7: begin
        base = $urandom_range(0, 253);
        p = make_pixel(base + $urandom_range(0, 2), base + $urandom_range(0, 2),
                       base + $urandom_range(0, 2), p.alpha);
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_pixel(rgbhsv_pkg::pix_in_t pix);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= pix;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  always @(posedge clk_i) begin
    if (quiet || !rst_ni) begin
      out_ready_i <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 20) begin
      out_ready_i <= 1'b0;
      stall_left <= idle_length() - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_pixel(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_hsv(out_data_o);
    end
  end

  initial begin
    #(20 * 400000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned blk, i;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corners, primaries, ties, gray levels and the red sector wrap.
    send_pixel(make_pixel(0, 0, 0, 0));
    send_pixel(make_pixel(255, 255, 255, 255));
    send_pixel(make_pixel(128, 128, 128, 77));
    send_pixel(make_pixel(255, 0, 0, 1));
    send_pixel(make_pixel(0, 255, 0, 2));
    send_pixel(make_pixel(0, 0, 255, 3));
    send_pixel(make_pixel(255, 255, 0, 170));
    send_pixel(make_pixel(0, 255, 255, 85));
    send_pixel(make_pixel(255, 0, 255, 254));
    send_pixel(make_pixel(255, 0, 1, 128));
    send_pixel(make_pixel(255, 1, 0, 127));
    send_pixel(make_pixel(1, 0, 0, 0));
    send_pixel(make_pixel(255, 254, 254, 255));
    send_pixel(make_pixel(1, 1, 0, 15));
    send_pixel(make_pixel(0, 1, 1, 240));
    send_pixel(make_pixel(10, 200, 100, 60));
    send_pixel(make_pixel(50, 20, 240, 195));
    send_pixel(make_pixel(240, 20, 50, 90));
    send_pixel(make_pixel(200, 200, 199, 33));
    send_pixel(make_pixel(0, 0, 1, 204));
    send_pixel(make_pixel(170, 85, 0, 51));
    send_pixel(make_pixel(85, 170, 255, 102));
    send_pixel(make_pixel(255, 128, 0, 128));
    send_pixel(make_pixel(1, 0, 1, 254));

    // Every third block runs with no idling on either side.
    for (blk = 0; blk < 11; blk++) begin
      quiet <= (blk % 3 == 1);
      for (i = 0; i < 100; i++) send_pixel(random_pixel());
    end
    in_valid_i <= 1'b0;
    quiet <= 1'b0;

    while (sb.expected_hsv.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("Converted %0d pixels and checked %0d HSV results, %0d mismatching.",
             sb.pixels_in, sb.results_checked, sb.mismatches);
    $display("Stimulus: channel extremes, gray and tied pixels, near-gray and random colors.");
    if (sb.mismatches == 0 && sb.expected_hsv.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
